FILE: design/gsfp_pkg.sv
// Shared types, constants and helpers for the GNSS sentence field parser.
// Depends on nothing; used by every module in this folder.
`timescale 1ns / 1ps

package gsfp_pkg;

  // Sizing
  localparam int BUFFER_BYTES         = 384;
  localparam int MAX_FIELD_INDEX      = 24;
  localparam int KNOT_FRACTION_DIGITS = 3;

  localparam int BYTE_W  = 8;
  localparam int FIELD_W = 5;
  localparam int KEPT_W  = $clog2(BUFFER_BYTES + 1);
  localparam int KNOTS_W = 24;
  localparam int SPEED_W = 23;
  localparam int QUAL_W  = 8;
  localparam int PHASE_W = 3;
  localparam int POW_W   = 14;

  localparam logic [KNOTS_W-1:0] KNOTS_MAX = {KNOTS_W{1'b1}};
  localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};
  localparam logic [QUAL_W-1:0]  QUAL_MAX  = {QUAL_W{1'b1}};

  localparam int KNOT_SCALE = 10 ** KNOT_FRACTION_DIGITS;

  // knots * 1852000 / (3600 * 10^D) reduces to knots * 463 / (9 * 10^(D-1))
  localparam int SPEED_NUM = 463;
  localparam int SPEED_DEN = 9 * (10 ** (KNOT_FRACTION_DIGITS - 1));
  localparam int NUM_W     = $clog2(SPEED_NUM + 1);
  localparam int SPX_W     = KNOTS_W + NUM_W;
  localparam int DEN_L     = $clog2(SPEED_DEN);
  localparam int SPEED_SHIFT = SPX_W + DEN_L;
  localparam int RECIP_W   = SPX_W + 1;
  localparam logic [63:0] SPEED_RECIP64 =
      ((64'd1 << SPEED_SHIFT) + 64'(SPEED_DEN) - 64'd1) / 64'(SPEED_DEN);
  localparam int RLO_W     = RECIP_W / 2;
  localparam int RHI_W     = RECIP_W - RLO_W;
  localparam logic [RLO_W-1:0] SPEED_RECIP_LO = SPEED_RECIP64[RLO_W-1:0];
  localparam logic [RHI_W-1:0] SPEED_RECIP_HI = SPEED_RECIP64[RECIP_W-1:RLO_W];
  localparam int SUM_W     = SPX_W + RECIP_W;
  localparam int SPEED_LAT = 3;

  // Output queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Characters
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
  localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
  localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
  localparam logic [BYTE_W-1:0] CH_H      = 8'h48;
  localparam logic [BYTE_W-1:0] CH_P      = 8'h50;
  localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
  localparam logic [BYTE_W-1:0] CH_T      = 8'h54;
  localparam logic [BYTE_W-1:0] CH_V      = 8'h56;

  // Codes
  localparam logic KIND_FIELD = 1'b0;
  localparam logic KIND_END   = 1'b1;

  localparam int MATCH_GGA = 0;
  localparam int MATCH_VTG = 1;
  localparam int MATCH_HPR = 2;

  localparam logic [1:0] CODE_NONE = 2'd0;
  localparam logic [1:0] CODE_GGA  = 2'd1;
  localparam logic [1:0] CODE_VTG  = 2'd2;
  localparam logic [1:0] CODE_HPR  = 2'd3;

  localparam logic [PHASE_W-1:0] PH_LEAD  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_INT   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_FRAC  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DONE  = 3'd7;
  localparam logic [PHASE_W-1:0] PH_TOP   = 3'(2 + KNOT_FRACTION_DIGITS);

  localparam logic [FIELD_W-1:0] FLD_NUM   = 5'd5;

  typedef struct packed {
    logic                kind;
    logic [2:0]          match_mask;
    logic [FIELD_W-1:0]  field_number;
    logic [BYTE_W-1:0]   field_byte;
    logic [1:0]          sentence_code;
    logic [SPEED_W-1:0]  speed;
    logic [QUAL_W-1:0]   quality;
    logic                overflowed;
    logic                last;
  } gsfp_result_t;

  typedef struct packed {
    logic          valid;
    gsfp_result_t  res;
  } gsfp_push_t;

  typedef struct packed {
    logic room_one;
    logic room_two;
  } gsfp_qstat_t;

  typedef struct packed {
    logic               settled;
    logic [SPEED_W-1:0] speed;
  } gsfp_speed_t;

  function automatic logic [POW_W-1:0] pow10(input logic [PHASE_W-1:0] n);
    logic [POW_W-1:0] r;
    case (n)
      3'd0:    r = 14'd1;
      3'd1:    r = 14'd10;
      3'd2:    r = 14'd100;
      3'd3:    r = 14'd1000;
      default: r = 14'd10000;
    endcase
    return r;
  endfunction

endpackage

FILE: design/gnss_sentence_field_parser_top.sv
// GNSS sentence field parser top: input holding register, parser, speed
// pipeline and result queue. Uses gsfp_pkg and all gsfp_* modules.
// A field item passes the input holding register, then a queue register.
// Throughput: one byte per cycle while the queue has room and no end item is
// pending. The end item waits until the 3-stage speed conversion has settled.
// Reset (rst, synchronous): clears parser state and empties the queue.
`timescale 1ns / 1ps

module gnss_sentence_field_parser_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rx_valid,
  output logic                            rx_stall,
  input  logic [gsfp_pkg::BYTE_W-1:0]     rx_byte,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic                            kind,
  output logic [2:0]                      match_mask,
  output logic [gsfp_pkg::FIELD_W-1:0]    field_number,
  output logic [gsfp_pkg::BYTE_W-1:0]     field_byte,
  output logic [1:0]                      sentence_code,
  output logic [gsfp_pkg::SPEED_W-1:0]    speed_mm_per_s,
  output logic [gsfp_pkg::QUAL_W-1:0]     solution_quality,
  output logic                            overflowed,
  output logic                            last
);

  logic                          hold_valid;
  logic [gsfp_pkg::BYTE_W-1:0]   hold_byte;
  logic                          take;
  logic                          rx_accept;
  logic [gsfp_pkg::KNOTS_W-1:0]  knots;
  gsfp_pkg::gsfp_speed_t         spd;
  gsfp_pkg::gsfp_qstat_t         qstat;
  gsfp_pkg::gsfp_push_t          push0;
  gsfp_pkg::gsfp_push_t          push1;
  gsfp_pkg::gsfp_result_t        res;

  assign rx_stall  = hold_valid && !take;
  assign rx_accept = rx_valid && !rx_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (rx_accept) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_accept) begin
      hold_byte <= rx_byte;
    end
  end

  gsfp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte),
    .qstat      (qstat),
    .spd        (spd),
    .take       (take),
    .knots      (knots),
    .push0      (push0),
    .push1      (push1)
  );

  gsfp_speed u_speed (
    .clk   (clk),
    .rst   (rst),
    .knots (knots),
    .info  (spd)
  );

  gsfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push0     (push0),
    .push1     (push1),
    .qstat     (qstat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  assign kind             = res.kind;
  assign match_mask       = res.match_mask;
  assign field_number     = res.field_number;
  assign field_byte       = res.field_byte;
  assign sentence_code    = res.sentence_code;
  assign speed_mm_per_s   = res.speed;
  assign solution_quality = res.quality;
  assign overflowed       = res.overflowed;
  assign last             = res.last;

endmodule

FILE: design/gsfp_speed.sv
// Knots-to-mm/s conversion pipeline: multiply, reciprocal divide, saturate.
// Uses gsfp_pkg. Tracks whether its output reflects the current knots value.
`timescale 1ns / 1ps

module gsfp_speed (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [gsfp_pkg::KNOTS_W-1:0]  knots,
  output gsfp_pkg::gsfp_speed_t         info
);

  logic [gsfp_pkg::KNOTS_W-1:0]              knots_d;
  logic [gsfp_pkg::SPX_W-1:0]                scaled;
  logic [gsfp_pkg::SPX_W+gsfp_pkg::RLO_W-1:0] pp_lo;
  logic [gsfp_pkg::SPX_W+gsfp_pkg::RHI_W-1:0] pp_hi;
  logic [gsfp_pkg::SUM_W-1:0]                sum;
  logic [gsfp_pkg::SUM_W-1:0]                quot;
  logic [gsfp_pkg::SPEED_W-1:0]              speed;
  logic [1:0]                                age;
  logic [1:0]                                age_next;

  // exact floor(scaled / DEN) for every scaled below 2^SPX_W
  assign sum  = {pp_hi, {gsfp_pkg::RLO_W{1'b0}}} + gsfp_pkg::SUM_W'(pp_lo);
  assign quot = sum >> gsfp_pkg::SPEED_SHIFT;

  always_comb begin
    if (knots != knots_d) begin
      age_next = 2'd1;
    end else if (age != 2'(gsfp_pkg::SPEED_LAT)) begin
      age_next = age + 2'd1;
    end else begin
      age_next = age;
    end
  end

  always_ff @(posedge clk) begin
    knots_d <= knots;
    scaled  <= gsfp_pkg::SPX_W'(knots) * gsfp_pkg::SPX_W'(gsfp_pkg::SPEED_NUM);
    pp_lo   <= (gsfp_pkg::SPX_W+gsfp_pkg::RLO_W)'(scaled) *
               (gsfp_pkg::SPX_W+gsfp_pkg::RLO_W)'(gsfp_pkg::SPEED_RECIP_LO);
    pp_hi   <= (gsfp_pkg::SPX_W+gsfp_pkg::RHI_W)'(scaled) *
               (gsfp_pkg::SPX_W+gsfp_pkg::RHI_W)'(gsfp_pkg::SPEED_RECIP_HI);
    if (quot > gsfp_pkg::SUM_W'(gsfp_pkg::SPEED_MAX)) begin
      speed <= gsfp_pkg::SPEED_MAX;
    end else begin
      speed <= quot[gsfp_pkg::SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      age <= 2'd0;
    end else begin
      age <= age_next;
    end
  end

  assign info.settled = (age == 2'(gsfp_pkg::SPEED_LAT)) && (knots == knots_d);
  assign info.speed   = speed;

endmodule

FILE: design/gsfp_parse.sv
// Per-byte sentence state: keep/drop, field counting, type match, number
// parsing and result generation. Uses gsfp_pkg.
`timescale 1ns / 1ps

module gsfp_parse (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          hold_valid,
  input  logic [gsfp_pkg::BYTE_W-1:0]   hold_byte,
  input  gsfp_pkg::gsfp_qstat_t         qstat,
  input  gsfp_pkg::gsfp_speed_t         spd,
  output logic                          take,
  output logic [gsfp_pkg::KNOTS_W-1:0]  knots,
  output gsfp_pkg::gsfp_push_t          push0,
  output gsfp_pkg::gsfp_push_t          push1
);

  localparam int KSUM_W = gsfp_pkg::KNOTS_W + 5;
  localparam int QSUM_W = gsfp_pkg::QUAL_W + 4;

  logic                          collecting, collecting_next;
  logic                          seen_cr, seen_cr_next;
  logic                          seen_lf, seen_lf_next;
  logic [gsfp_pkg::KEPT_W-1:0]   kept_count, kept_count_next;
  logic [gsfp_pkg::FIELD_W-1:0]  cur_field, cur_field_next;
  logic [15:0]                   tail, tail_next;
  logic [2:0]                    type_hits, type_hits_next;
  logic [gsfp_pkg::KNOTS_W-1:0]  knots_next;
  logic [gsfp_pkg::PHASE_W-1:0]  kphase, kphase_next;
  logic [gsfp_pkg::QUAL_W-1:0]   qual, qual_next;
  logic                          qual_done, qual_done_next;
  logic                          qual_started, qual_started_next;
  logic                          overflow_seen, overflow_next;
  logic                          end_pending, end_pending_next;

  logic                          flush;
  logic                          keep;
  logic                          sep;
  logic                          digit;
  logic                          space;
  logic [3:0]                    dval;
  logic [KSUM_W-1:0]             int_sum;
  logic [KSUM_W-1:0]             frac_sum;
  logic [QSUM_W-1:0]             qsum;
  logic                          end_now;
  logic                          fld_v;
  logic                          end_v;
  gsfp_pkg::gsfp_result_t        fld_res;
  gsfp_pkg::gsfp_result_t        end_res;

  function automatic logic wanted(input logic [gsfp_pkg::FIELD_W-1:0] f,
                                  input logic [2:0] m);
    logic w;
    w = 1'b0;
    if (m[gsfp_pkg::MATCH_GGA] && ((f >= 5'd1 && f <= 5'd9) || f == 5'd13)) w = 1'b1;
    if (m[gsfp_pkg::MATCH_VTG] && (f == 5'd1 || f == 5'd5)) w = 1'b1;
    if (m[gsfp_pkg::MATCH_HPR] && (f == 5'd2 || f == 5'd3 || f == 5'd5)) w = 1'b1;
    return w;
  endfunction

  assign take  = hold_valid && !end_pending && qstat.room_two;
  assign flush = end_pending && spd.settled && qstat.room_one;

  assign digit = (hold_byte >= gsfp_pkg::CH_ZERO) && (hold_byte <= gsfp_pkg::CH_NINE);
  assign space = (hold_byte == gsfp_pkg::CH_SPACE) ||
                 ((hold_byte >= gsfp_pkg::CH_TAB) && (hold_byte <= gsfp_pkg::CH_CR));
  assign dval  = hold_byte[3:0];

  assign int_sum  = KSUM_W'(knots) * KSUM_W'(10) +
                    KSUM_W'(dval) * KSUM_W'(gsfp_pkg::KNOT_SCALE);
  // fraction digit k (phase 2+k-1) weighs 10^(D-k)
  assign frac_sum = KSUM_W'(knots) + KSUM_W'(dval) *
                    KSUM_W'(gsfp_pkg::pow10(3'(gsfp_pkg::KNOT_FRACTION_DIGITS + 1) - kphase));
  assign qsum     = QSUM_W'(qual) * QSUM_W'(10) + QSUM_W'(dval);

  always_comb begin
    collecting_next   = collecting;
    seen_cr_next      = seen_cr;
    seen_lf_next      = seen_lf;
    kept_count_next   = kept_count;
    cur_field_next    = cur_field;
    tail_next         = tail;
    type_hits_next    = type_hits;
    knots_next        = knots;
    kphase_next       = kphase;
    qual_next         = qual;
    qual_done_next    = qual_done;
    qual_started_next = qual_started;
    overflow_next     = overflow_seen;
    end_pending_next  = end_pending;
    keep              = 1'b0;
    sep               = 1'b0;
    fld_v             = 1'b0;
    end_now           = 1'b0;

    if (take) begin
      if (hold_byte == gsfp_pkg::CH_DOLLAR) begin
        keep            = 1'b1;
        collecting_next = 1'b1;
      end else if (hold_byte == gsfp_pkg::CH_CR) begin
        keep            = 1'b1;
        seen_cr_next    = 1'b1;
        collecting_next = 1'b0;
      end else if (hold_byte == gsfp_pkg::CH_LF) begin
        keep            = 1'b1;
        seen_lf_next    = 1'b1;
        collecting_next = 1'b0;
      end else begin
        keep = collecting;
      end

      if (keep) begin
        if (kept_count >= gsfp_pkg::KEPT_W'(gsfp_pkg::BUFFER_BYTES)) begin
          overflow_next = 1'b1;
        end else begin
          kept_count_next = kept_count + 1'b1;
          sep = ((hold_byte == gsfp_pkg::CH_STAR) || (hold_byte == gsfp_pkg::CH_SEMI) ||
                 (hold_byte == gsfp_pkg::CH_COMMA)) &&
                (cur_field < gsfp_pkg::FIELD_W'(gsfp_pkg::MAX_FIELD_INDEX));
          if (sep) begin
            cur_field_next = cur_field + 1'b1;
          end else begin
            if (cur_field == '0) begin
              if (tail[15:8] == gsfp_pkg::CH_G && tail[7:0] == gsfp_pkg::CH_G &&
                  hold_byte == gsfp_pkg::CH_A) begin
                type_hits_next[gsfp_pkg::MATCH_GGA] = 1'b1;
              end
              if (tail[15:8] == gsfp_pkg::CH_V && tail[7:0] == gsfp_pkg::CH_T &&
                  hold_byte == gsfp_pkg::CH_G) begin
                type_hits_next[gsfp_pkg::MATCH_VTG] = 1'b1;
              end
              if (tail[15:8] == gsfp_pkg::CH_H && tail[7:0] == gsfp_pkg::CH_P &&
                  hold_byte == gsfp_pkg::CH_R) begin
                type_hits_next[gsfp_pkg::MATCH_HPR] = 1'b1;
              end
              tail_next = {tail[7:0], hold_byte};
            end

            if (cur_field == gsfp_pkg::FLD_NUM) begin
              // speed text
              if (kphase != gsfp_pkg::PH_DONE) begin
                if (digit) begin
                  if (kphase <= gsfp_pkg::PH_INT) begin
                    knots_next  = (int_sum > KSUM_W'(gsfp_pkg::KNOTS_MAX)) ?
                                  gsfp_pkg::KNOTS_MAX : int_sum[gsfp_pkg::KNOTS_W-1:0];
                    kphase_next = gsfp_pkg::PH_INT;
                  end else if (kphase < gsfp_pkg::PH_TOP) begin
                    knots_next  = (frac_sum > KSUM_W'(gsfp_pkg::KNOTS_MAX)) ?
                                  gsfp_pkg::KNOTS_MAX : frac_sum[gsfp_pkg::KNOTS_W-1:0];
                    kphase_next = kphase + 1'b1;
                  end
                end else if (hold_byte == gsfp_pkg::CH_DOT && kphase <= gsfp_pkg::PH_INT) begin
                  kphase_next = gsfp_pkg::PH_FRAC;
                end else if (kphase == gsfp_pkg::PH_LEAD && space) begin
                  kphase_next = kphase;
                end else if (kphase == gsfp_pkg::PH_LEAD && hold_byte == gsfp_pkg::CH_PLUS) begin
                  kphase_next = gsfp_pkg::PH_INT;
                end else begin
                  if (kphase == gsfp_pkg::PH_LEAD && hold_byte == gsfp_pkg::CH_MINUS) begin
                    knots_next = '0;
                  end
                  kphase_next = gsfp_pkg::PH_DONE;
                end
              end

              // quality text
              if (!qual_done) begin
                if (digit) begin
                  qual_next = (qsum > QSUM_W'(gsfp_pkg::QUAL_MAX)) ?
                              gsfp_pkg::QUAL_MAX : qsum[gsfp_pkg::QUAL_W-1:0];
                  qual_started_next = 1'b1;
                end else if (!qual_started && space) begin
                  qual_done_next = 1'b0;
                end else if (!qual_started && hold_byte == gsfp_pkg::CH_PLUS) begin
                  qual_started_next = 1'b1;
                end else begin
                  if (!qual_started && hold_byte == gsfp_pkg::CH_MINUS) begin
                    qual_next = '0;
                  end
                  qual_done_next = 1'b1;
                end
              end
            end

            fld_v = wanted(cur_field, type_hits_next);
          end
        end
      end
      end_now = seen_cr_next && seen_lf_next;
    end

    end_v = (end_now && spd.settled) || flush;

    fld_res.kind          = gsfp_pkg::KIND_FIELD;
    fld_res.match_mask    = type_hits_next;
    fld_res.field_number  = cur_field;
    fld_res.field_byte    = hold_byte;
    fld_res.sentence_code = gsfp_pkg::CODE_NONE;
    fld_res.speed         = '0;
    fld_res.quality       = '0;
    fld_res.overflowed    = 1'b0;
    fld_res.last          = !end_now;

    end_res.kind          = gsfp_pkg::KIND_END;
    end_res.match_mask    = type_hits_next;
    end_res.field_number  = '0;
    end_res.field_byte    = '0;
    if (type_hits_next[gsfp_pkg::MATCH_HPR]) begin
      end_res.sentence_code = gsfp_pkg::CODE_HPR;
    end else if (type_hits_next[gsfp_pkg::MATCH_VTG]) begin
      end_res.sentence_code = gsfp_pkg::CODE_VTG;
    end else if (type_hits_next[gsfp_pkg::MATCH_GGA]) begin
      end_res.sentence_code = gsfp_pkg::CODE_GGA;
    end else begin
      end_res.sentence_code = gsfp_pkg::CODE_NONE;
    end
    end_res.speed      = type_hits_next[gsfp_pkg::MATCH_VTG] ? spd.speed : '0;
    end_res.quality    = type_hits_next[gsfp_pkg::MATCH_HPR] ? qual_next : '0;
    end_res.overflowed = overflow_next;
    end_res.last       = 1'b1;

    // sentence done: back to the idle state
    if (end_v) begin
      collecting_next   = 1'b0;
      seen_cr_next      = 1'b0;
      seen_lf_next      = 1'b0;
      kept_count_next   = '0;
      cur_field_next    = '0;
      tail_next         = '0;
      type_hits_next    = '0;
      knots_next        = '0;
      kphase_next       = gsfp_pkg::PH_LEAD;
      qual_next         = '0;
      qual_done_next    = 1'b0;
      qual_started_next = 1'b0;
      overflow_next     = 1'b0;
      end_pending_next  = 1'b0;
    end else if (end_now) begin
      // speed pipeline still catching up; end item follows later
      end_pending_next  = 1'b1;
    end

    push0.valid = fld_v || end_v;
    push0.res   = fld_v ? fld_res : end_res;
    push1.valid = fld_v && end_v;
    push1.res   = end_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting    <= 1'b0;
      seen_cr       <= 1'b0;
      seen_lf       <= 1'b0;
      kept_count    <= '0;
      cur_field     <= '0;
      tail          <= '0;
      type_hits     <= '0;
      knots         <= '0;
      kphase        <= gsfp_pkg::PH_LEAD;
      qual          <= '0;
      qual_done     <= 1'b0;
      qual_started  <= 1'b0;
      overflow_seen <= 1'b0;
      end_pending   <= 1'b0;
    end else begin
      collecting    <= collecting_next;
      seen_cr       <= seen_cr_next;
      seen_lf       <= seen_lf_next;
      kept_count    <= kept_count_next;
      cur_field     <= cur_field_next;
      tail          <= tail_next;
      type_hits     <= type_hits_next;
      knots         <= knots_next;
      kphase        <= kphase_next;
      qual          <= qual_next;
      qual_done     <= qual_done_next;
      qual_started  <= qual_started_next;
      overflow_seen <= overflow_next;
      end_pending   <= end_pending_next;
    end
  end

endmodule

FILE: design/gsfp_queue.sv
// Result queue: small register FIFO taking up to two items per cycle and
// handing out one while res_stall is low. Uses gsfp_pkg.
`timescale 1ns / 1ps

module gsfp_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  gsfp_pkg::gsfp_push_t    push0,
  input  gsfp_pkg::gsfp_push_t    push1,
  output gsfp_pkg::gsfp_qstat_t   qstat,
  output logic                    res_valid,
  input  logic                    res_stall,
  output gsfp_pkg::gsfp_result_t  res
);

  gsfp_pkg::gsfp_result_t       entries [gsfp_pkg::QDEPTH];
  logic [gsfp_pkg::QPTR_W-1:0]  head;
  logic [gsfp_pkg::QPTR_W-1:0]  tail;
  logic [gsfp_pkg::QCNT_W-1:0]  count;
  logic [gsfp_pkg::QCNT_W-1:0]  count_next;
  logic                         pop;

  assign res_valid = (count != '0);
  assign pop       = res_valid && !res_stall;
  assign res       = entries[head];

  assign qstat.room_one = (count <= gsfp_pkg::QCNT_W'(gsfp_pkg::QDEPTH - 1));
  assign qstat.room_two = (count <= gsfp_pkg::QCNT_W'(gsfp_pkg::QDEPTH - 2));

  assign count_next = count + gsfp_pkg::QCNT_W'(push0.valid) +
                      gsfp_pkg::QCNT_W'(push1.valid) - gsfp_pkg::QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push0.valid) begin
      entries[tail] <= push0.res;
    end
    if (push1.valid) begin
      entries[tail + 1'b1] <= push1.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + 1'b1;
      end
      tail  <= tail + gsfp_pkg::QPTR_W'(push0.valid) + gsfp_pkg::QPTR_W'(push1.valid);
      count <= count_next;
    end
  end

endmodule

FILE: sim/gnss_sentence_field_parser_top_tb.sv
// Testbench for gnss_sentence_field_parser_top: feeds framed and noisy sentences,
// predicts every field and end item in-line and checks the result stream in order.
// Depends on gsfp_pkg and the design top only.
`timescale 1ns / 1ps

module gnss_sentence_field_parser_top_tb;

  localparam int PHASE_BYTES = 470;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           rx_valid = 1'b0;
  logic                           rx_stall;
  logic [gsfp_pkg::BYTE_W-1:0]    rx_byte = '0;
  logic                           res_valid;
  logic                           res_stall = 1'b0;
  logic                           kind;
  logic [2:0]                     match_mask;
  logic [gsfp_pkg::FIELD_W-1:0]   field_number;
  logic [gsfp_pkg::BYTE_W-1:0]    field_byte;
  logic [1:0]                     sentence_code;
  logic [gsfp_pkg::SPEED_W-1:0]   speed_mm_per_s;
  logic [gsfp_pkg::QUAL_W-1:0]    solution_quality;
  logic                           overflowed;
  logic                           last;

  gnss_sentence_field_parser_top i_dut (.*);

  // stimulus and expectations
  logic [gsfp_pkg::BYTE_W-1:0] tx_bytes[$];
  gsfp_pkg::gsfp_result_t      due_results[$];
  int                idle_pct = 0;
  int                stall_pct = 0;
  int                bytes_queued = 0;
  int                bytes_fed = 0;
  int                results_checked = 0;
  int                ends_checked = 0;
  int                overflow_ends = 0;
  int                error_count = 0;
  int                phase_start;
  logic              rx_fire = 1'b0;
  gsfp_pkg::gsfp_result_t got_res, exp_res;

  // predicted parser state
  logic              p_collecting, p_seen_cr, p_seen_lf;
  int unsigned       p_kept;
  logic [4:0]        p_field;
  logic [15:0]       p_tail;
  logic [2:0]        p_match;
  logic [gsfp_pkg::KNOTS_W-1:0] p_knots;
  logic [gsfp_pkg::PHASE_W-1:0] p_phase;
  logic [gsfp_pkg::QUAL_W-1:0]  p_qual;
  logic              p_qual_done, p_qual_started, p_overflow;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic string fmt_result(input gsfp_pkg::gsfp_result_t r);
    return $sformatf({"kind=%0d mask=%0d field=%0d byte=%02h code=%0d speed=%0d",
                      " qual=%0d ovf=%0d last=%0d"},
                     r.kind, r.match_mask, r.field_number, r.field_byte, r.sentence_code,
                     r.speed, r.quality, r.overflowed, r.last);
  endfunction

  task automatic clear_parser();
    p_collecting   = 1'b0;
    p_seen_cr      = 1'b0;
    p_seen_lf      = 1'b0;
    p_kept         = 0;
    p_field        = '0;
    p_tail         = '0;
    p_match        = '0;
    p_knots        = '0;
    p_phase        = gsfp_pkg::PH_LEAD;
    p_qual         = '0;
    p_qual_done    = 1'b0;
    p_qual_started = 1'b0;
    p_overflow     = 1'b0;
  endtask

  // Works out the items caused by one accepted byte and queues them.
  task automatic parse_rx_byte(input logic [gsfp_pkg::BYTE_W-1:0] c);
    logic          keep, sep, digit, blank, have_field, end_now;
    logic [3:0]    d;
    int unsigned   k_next, frac_w, qn;
    longint unsigned spd;
    gsfp_pkg::gsfp_result_t rf, re;
    have_field = 1'b0;
    rf = '0;
    keep = p_collecting;
    if (c == gsfp_pkg::CH_DOLLAR) begin
      keep = 1'b1;
      p_collecting = 1'b1;
    end else if (c == gsfp_pkg::CH_CR) begin
      keep = 1'b1;
      p_seen_cr = 1'b1;
      p_collecting = 1'b0;
    end else if (c == gsfp_pkg::CH_LF) begin
      keep = 1'b1;
      p_seen_lf = 1'b1;
      p_collecting = 1'b0;
    end

    if (keep) begin
      if (p_kept >= gsfp_pkg::BUFFER_BYTES) begin
        p_overflow = 1'b1;
      end else begin
        sep = (c == gsfp_pkg::CH_STAR || c == gsfp_pkg::CH_SEMI || c == gsfp_pkg::CH_COMMA) &&
              p_field < gsfp_pkg::MAX_FIELD_INDEX;
        p_kept++;
        if (sep) begin
          p_field++;
        end else begin
          if (p_field == 0) begin
            if (p_tail == {gsfp_pkg::CH_G, gsfp_pkg::CH_G} && c == gsfp_pkg::CH_A)
              p_match[gsfp_pkg::MATCH_GGA] = 1'b1;
            if (p_tail == {gsfp_pkg::CH_V, gsfp_pkg::CH_T} && c == gsfp_pkg::CH_G)
              p_match[gsfp_pkg::MATCH_VTG] = 1'b1;
            if (p_tail == {gsfp_pkg::CH_H, gsfp_pkg::CH_P} && c == gsfp_pkg::CH_R)
              p_match[gsfp_pkg::MATCH_HPR] = 1'b1;
            p_tail = {p_tail[7:0], c};
          end
          if (p_field == gsfp_pkg::FLD_NUM) begin
            digit = c >= gsfp_pkg::CH_ZERO && c <= gsfp_pkg::CH_NINE;
            blank = c == gsfp_pkg::CH_SPACE || (c >= gsfp_pkg::CH_TAB && c <= gsfp_pkg::CH_CR);
            d = 4'(c - gsfp_pkg::CH_ZERO);
            // speed text, knots scaled by 10^fraction digits
            if (p_phase != gsfp_pkg::PH_DONE) begin
              if (digit) begin
                if (p_phase <= gsfp_pkg::PH_INT) begin
                  k_next = 32'(p_knots) * 10 + 32'(d) * gsfp_pkg::KNOT_SCALE;
                  p_knots = k_next > gsfp_pkg::KNOTS_MAX ? gsfp_pkg::KNOTS_MAX
                                                         : k_next[gsfp_pkg::KNOTS_W-1:0];
                  p_phase = gsfp_pkg::PH_INT;
                end else if (p_phase < gsfp_pkg::PH_TOP) begin
                  frac_w = gsfp_pkg::KNOT_SCALE;
                  repeat (p_phase - 1) frac_w = frac_w / 10;
                  k_next = 32'(p_knots) + 32'(d) * frac_w;
                  p_knots = k_next > gsfp_pkg::KNOTS_MAX ? gsfp_pkg::KNOTS_MAX
                                                         : k_next[gsfp_pkg::KNOTS_W-1:0];
                  p_phase = p_phase + 1;
                end
              end else if (c == gsfp_pkg::CH_DOT && p_phase <= gsfp_pkg::PH_INT) begin
                p_phase = gsfp_pkg::PH_FRAC;
              end else if (p_phase == gsfp_pkg::PH_LEAD && c == gsfp_pkg::CH_PLUS) begin
                p_phase = gsfp_pkg::PH_INT;
              end else if (!(p_phase == gsfp_pkg::PH_LEAD && blank)) begin
                if (p_phase == gsfp_pkg::PH_LEAD && c == gsfp_pkg::CH_MINUS) p_knots = '0;
                p_phase = gsfp_pkg::PH_DONE;
              end
            end
            // solution quality, leading integer
            if (!p_qual_done) begin
              if (digit) begin
                qn = 32'(p_qual) * 10 + 32'(d);
                p_qual = qn > gsfp_pkg::QUAL_MAX ? gsfp_pkg::QUAL_MAX
                                                 : qn[gsfp_pkg::QUAL_W-1:0];
                p_qual_started = 1'b1;
              end else if (!p_qual_started && c == gsfp_pkg::CH_PLUS) begin
                p_qual_started = 1'b1;
              end else if (!(!p_qual_started && blank)) begin
                if (!p_qual_started && c == gsfp_pkg::CH_MINUS) p_qual = '0;
                p_qual_done = 1'b1;
              end
            end
          end
          if ((p_match[gsfp_pkg::MATCH_GGA] &&
               ((p_field >= 1 && p_field <= 9) || p_field == 13)) ||
              (p_match[gsfp_pkg::MATCH_VTG] && (p_field == 1 || p_field == 5)) ||
              (p_match[gsfp_pkg::MATCH_HPR] &&
               (p_field == 2 || p_field == 3 || p_field == 5))) begin
            have_field      = 1'b1;
            rf.kind         = gsfp_pkg::KIND_FIELD;
            rf.match_mask   = p_match;
            rf.field_number = p_field;
            rf.field_byte   = c;
          end
        end
      end
    end

    end_now = p_seen_cr && p_seen_lf;
    if (have_field) begin
      rf.last = !end_now;
      due_results.push_back(rf);
    end
    if (end_now) begin
      re = '0;
      re.kind = gsfp_pkg::KIND_END;
      re.match_mask = p_match;
      if (p_match[gsfp_pkg::MATCH_HPR])      re.sentence_code = gsfp_pkg::CODE_HPR;
      else if (p_match[gsfp_pkg::MATCH_VTG]) re.sentence_code = gsfp_pkg::CODE_VTG;
      else if (p_match[gsfp_pkg::MATCH_GGA]) re.sentence_code = gsfp_pkg::CODE_GGA;
      else                                   re.sentence_code = gsfp_pkg::CODE_NONE;
      if (p_match[gsfp_pkg::MATCH_VTG]) begin
        spd = 64'(p_knots) * 64'd1852000 / (64'd3600 * gsfp_pkg::KNOT_SCALE);
        re.speed = spd > gsfp_pkg::SPEED_MAX ? gsfp_pkg::SPEED_MAX
                                             : spd[gsfp_pkg::SPEED_W-1:0];
      end
      if (p_match[gsfp_pkg::MATCH_HPR]) re.quality = p_qual;
      re.overflowed = p_overflow;
      re.last = 1'b1;
      due_results.push_back(re);
      clear_parser();
    end
  endtask

  // accepted bytes feed the prediction; accepted items are checked in order
  always @(posedge clk) begin
    rx_fire = !rst && rx_valid && !rx_stall;
    if (rst) begin
      clear_parser();
    end else begin
      if (rx_fire) begin
        parse_rx_byte(rx_byte);
        bytes_fed++;
      end
      if (res_valid && !res_stall) begin
        got_res = '{kind, match_mask, field_number, field_byte, sentence_code,
                    speed_mm_per_s, solution_quality, overflowed, last};
        results_checked++;
        if (due_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected item %s", $time, fmt_result(got_res));
        end else begin
          exp_res = due_results.pop_front();
          if (exp_res.kind == gsfp_pkg::KIND_END) begin
            ends_checked++;
            if (exp_res.overflowed) overflow_ends++;
          end
          if (got_res !== exp_res) begin
            error_count++;
            $display("%0t: mismatch expected %s", $time, fmt_result(exp_res));
            $display("%0t:          actual   %s", $time, fmt_result(got_res));
          end
        end
      end
    end
  end

  // byte driver: a held byte stays put until it is taken
  always @(negedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else if (!rx_valid || rx_fire) begin
      if (tx_bytes.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
        rx_valid <= 1'b1;
        rx_byte  <= tx_bytes.pop_front();
      end else begin
        rx_valid <= 1'b0;
      end
    end
    res_stall <= $urandom_range(99, 0) < stall_pct;
  end

  task automatic queue_byte(input logic [gsfp_pkg::BYTE_W-1:0] b);
    tx_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  function automatic logic [gsfp_pkg::BYTE_W-1:0] rand_text_char();
    case ($urandom_range(9, 0))
      0, 1, 2, 3: return gsfp_pkg::CH_ZERO + 8'($urandom_range(9, 0));
      4:          return gsfp_pkg::CH_DOT;
      5:          return gsfp_pkg::CH_A + 8'($urandom_range(25, 0));
      6:          return gsfp_pkg::CH_SPACE;
      7:          return gsfp_pkg::CH_MINUS;
      default:    return 8'($urandom_range(255, 0));
    endcase
  endfunction

  // field 5 text: blanks, sign, integer, fraction, maybe trailing junk
  task automatic queue_number_text();
    if ($urandom_range(3, 0) == 0)
      repeat ($urandom_range(2, 1))
        queue_byte($urandom_range(1, 0) ? gsfp_pkg::CH_SPACE : gsfp_pkg::CH_TAB);
    case ($urandom_range(7, 0))
      0:       queue_byte(gsfp_pkg::CH_PLUS);
      1:       queue_byte(gsfp_pkg::CH_MINUS);
      default: ;
    endcase
    repeat (($urandom_range(7, 0) == 0) ? $urandom_range(9, 5) : $urandom_range(3, 0))
      queue_byte(gsfp_pkg::CH_ZERO + 8'($urandom_range(9, 0)));
    if ($urandom_range(1, 0)) begin
      queue_byte(gsfp_pkg::CH_DOT);
      repeat ($urandom_range(5, 0)) queue_byte(gsfp_pkg::CH_ZERO + 8'($urandom_range(9, 0)));
    end
    if ($urandom_range(3, 0) == 0) queue_byte(rand_text_char());
  endtask

  task automatic queue_sentence(input bit long_tail);
    string head;
    int    n_fields;
    if ($urandom_range(3, 0) == 0)
      repeat ($urandom_range(4, 1)) queue_byte(8'($urandom_range(255, 0)));
    queue_byte(gsfp_pkg::CH_DOLLAR);
    case ($urandom_range(11, 0))
      0, 1:    head = "GPGGA";
      2:       head = "GNGGA";
      3, 4:    head = "GPVTG";
      5:       head = "GNVTG";
      6, 7:    head = "GNHPR";
      8:       head = "GGAVTGHPR";
      9:       head = "GGGA";
      10:      head = "GPGSV";
      default: begin
        head = "";
        repeat ($urandom_range(6, 2)) begin
          case ($urandom_range(6, 0))
            0: head = {head, "G"};
            1: head = {head, "A"};
            2: head = {head, "V"};
            3: head = {head, "T"};
            4: head = {head, "H"};
            5: head = {head, "P"};
            default: head = {head, "R"};
          endcase
        end
      end
    endcase
    queue_text(head);
    n_fields = ($urandom_range(7, 0) == 0) ? $urandom_range(30, gsfp_pkg::MAX_FIELD_INDEX)
                                           : $urandom_range(14, 3);
    for (int f = 1; f <= n_fields; f++) begin
      case ($urandom_range(7, 0))
        6:       queue_byte(gsfp_pkg::CH_SEMI);
        7:       queue_byte(gsfp_pkg::CH_STAR);
        default: queue_byte(gsfp_pkg::CH_COMMA);
      endcase
      if (f == gsfp_pkg::FLD_NUM) queue_number_text();
      else repeat ($urandom_range(4, 0)) queue_byte(rand_text_char());
    end
    // runs past the buffer so the end item reports an overflow
    if (long_tail)
      repeat (gsfp_pkg::BUFFER_BYTES + 20)
        queue_byte(gsfp_pkg::CH_ZERO + 8'($urandom_range(9, 0)));
    case ($urandom_range(15, 0))
      0: queue_text("\n\r");
      1: begin
        queue_byte(gsfp_pkg::CH_CR);
        repeat ($urandom_range(3, 1)) queue_byte(8'($urandom_range(255, 0)));
        queue_byte(gsfp_pkg::CH_LF);
      end
      2: ;  // unterminated, next sentence runs on
      default: queue_text("\r\n");
    endcase
  endtask

  task automatic wait_idle();
    while (tx_bytes.size() != 0 || rx_valid || due_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all three types in one header, every separator, zero byte, signed
    // speed with a truncated fraction
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_text("$HPRVTGGGA,");
    queue_byte(8'h00);
    queue_text(";*,,+12.3456\r\n");
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      phase_start = bytes_queued;
      if (ph % 2 == 1) queue_sentence(1'b1);
      while (bytes_queued - phase_start < PHASE_BYTES) queue_sentence(1'b0);
      wait_idle();
    end

    repeat (16) @(negedge clk);
    $display("Fed %0d bytes under four idle/stall mixes, checked %0d items",
             bytes_fed, results_checked);
    $display("Saw %0d sentence ends, %0d of them with buffer overflow",
             ends_checked, overflow_ends);
    if (error_count == 0) begin
      $display("gnss_sentence_field_parser_top_tb OK");
    end else begin
      $display("gnss_sentence_field_parser_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d items still due", due_results.size());
    $display("gnss_sentence_field_parser_top_tb NOT OK");
    $finish;
  end

endmodule
